// File: rtl/core/pod_pkg.sv
// Shared types, constants and helpers of the pattern occurrence distance core.
// No dependencies; every other file in rtl/core refers to it by scoped names.

package pod_pkg;

	localparam int PATTERN_MAX   = 16;
	localparam int PAT_IDX_BITS  = $clog2(PATTERN_MAX);
	localparam int PAT_LEN_BITS  = 5;
	localparam int POSITION_BITS = 48;
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_IDX_BITS  = 2;
	localparam int FIFO_DEPTH    = 8;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

	typedef logic [POSITION_BITS-1:0] pos_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_PATTERN_LENGTH = 2'd0,
		CFG_PATTERN_LOW    = 2'd1,
		CFG_PATTERN_HIGH   = 2'd2,
		CFG_REPORT_EACH    = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		KIND_MATCH   = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t kind;
		pos_t  match_position;
		pos_t  gap;
		pos_t  match_total;
		pos_t  gap_sum;
		logic  found_any;
		logic  run_end;
	} result_t;

	// Push request into the result queue: how many entries and their contents.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	// Clamp the configured length to 1..PATTERN_MAX and return length minus one.
	function automatic logic [PAT_IDX_BITS-1:0] eff_len_m1(input logic [PAT_LEN_BITS-1:0] len);
		logic [PAT_IDX_BITS-1:0] res;
		if (len == '0) begin
			res = '0;
		end else if (len > PAT_LEN_BITS'(PATTERN_MAX)) begin
			res = PAT_IDX_BITS'(PATTERN_MAX - 1);
		end else begin
			res = PAT_IDX_BITS'(len - PAT_LEN_BITS'(1));
		end
		return res;
	endfunction

endpackage

// File: rtl/core/pod_if.sv
// Valid/ready channel interfaces of the pattern occurrence distance core.
// Depends on pod_pkg for field widths.

interface pod_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface pod_result_if;
	logic              valid;
	logic              ready;
	logic              kind;
	pod_pkg::pos_t     match_position;
	pod_pkg::pos_t     gap;
	pod_pkg::pos_t     match_total;
	pod_pkg::pos_t     gap_sum;
	logic              found_any;
	logic              run_end;

	modport source (output valid, output kind, output match_position, output gap,
		output match_total, output gap_sum, output found_any, output run_end,
		input ready);
	modport sink   (input valid, input kind, input match_position, input gap,
		input match_total, input gap_sum, input found_any, input run_end,
		output ready);
endinterface

// File: rtl/core/pod_match.sv
// Sliding byte window and parallel pattern compare.
// Depends on pod_pkg.

module pod_match (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  logic                                clear,
	input  logic [7:0]                          data_byte,
	input  logic [pod_pkg::PAT_IDX_BITS-1:0]    len_m1,
	input  logic [pod_pkg::PATTERN_MAX*8-1:0]   pattern,
	output logic                                hit
);

	logic [7:0] win_q [pod_pkg::PATTERN_MAX];
	logic [7:0] nwin  [pod_pkg::PATTERN_MAX];
	logic [pod_pkg::PAT_IDX_BITS-1:0] idx [pod_pkg::PATTERN_MAX];
	logic [pod_pkg::PATTERN_MAX-1:0]  ok;

	// Window as it stands once the new byte is in, newest at slot 0.
	always_comb begin
		nwin[0] = data_byte;
		for (int j = 1; j < pod_pkg::PATTERN_MAX; j++) begin
			nwin[j] = win_q[j-1];
		end
	end

	// Slot j holds pattern byte len-1-j; slots past the length always agree.
	always_comb begin
		for (int j = 0; j < pod_pkg::PATTERN_MAX; j++) begin
			idx[j] = len_m1 - pod_pkg::PAT_IDX_BITS'(j);
			if (pod_pkg::PAT_IDX_BITS'(j) > len_m1) begin
				ok[j] = 1'b1;
			end else begin
				ok[j] = (nwin[j] == pattern[idx[j]*8 +: 8]);
			end
		end
		hit = &ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < pod_pkg::PATTERN_MAX; j++) win_q[j] <= '0;
		end else if (advance) begin
			for (int j = 0; j < pod_pkg::PATTERN_MAX; j++) begin
				win_q[j] <= clear ? 8'd0 : nwin[j];
			end
		end
	end

endmodule

// File: rtl/core/pod_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per cycle.
// Depends on pod_pkg.

module pod_result_fifo (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pod_pkg::push_t                     push,
	input  logic                               pop,
	output logic                               not_empty,
	output pod_pkg::result_t                   head,
	output logic [pod_pkg::FIFO_CNT_BITS-1:0]  fill
);

	pod_pkg::result_t mem [pod_pkg::FIFO_DEPTH];
	logic [pod_pkg::FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [pod_pkg::FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [pod_pkg::FIFO_CNT_BITS-1:0] cnt_q;
	logic [pod_pkg::FIFO_PTR_BITS-1:0] wr_ptr_p1;

	assign wr_ptr_p1 = wr_ptr_q + pod_pkg::FIFO_PTR_BITS'(1);
	assign not_empty = (cnt_q != '0);
	assign head      = mem[rd_ptr_q];
	assign fill      = cnt_q;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem[wr_ptr_q] <= push.first;
		if (push.count == 2'd2) mem[wr_ptr_p1] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + pod_pkg::FIFO_PTR_BITS'(push.count);
			if (pop) rd_ptr_q <= rd_ptr_q + pod_pkg::FIFO_PTR_BITS'(1);
			cnt_q <= cnt_q + pod_pkg::FIFO_CNT_BITS'(push.count)
				- pod_pkg::FIFO_CNT_BITS'(pop);
		end
	end

endmodule

// File: rtl/core/pattern_occurrence_distance_core.sv
// Pattern occurrence distance core: exact matching of a byte pattern in a stream.
// Depends on pod_pkg, pod_if, pod_match and pod_result_fifo.
//
// Usage:
//   bytes   - sink channel, one stream byte per item; end_of_stream marks the last.
//   results - source channel, match reports (kind 0, only with report_each set,
//             for every match after the first) and one summary (kind 1) per stream.
//   cfg_we/cfg_index/cfg_data - register writes, taken at any edge with cfg_we high;
//             write only while the core is idle.
// Timing:
//   The first result of a byte passes the input register, the compare/state update
//   and the gap subtract before it is presented; the sum accumulates on the write
//   into the result queue.
//   One byte per cycle is sustained while results are taken; a byte that yields
//   both a report and a summary puts two results into the queue. The 8-entry result
//   queue parts the two channels, and bytes keeps being taken while results wait,
//   until the queue has no room left for two more results per byte in flight.
// Reset:
//   arst_n clears the run state, the window, the queue and sets the registers to
//   length 1, pattern zero, reports off. The last byte of a stream clears the run
//   state after its summary; registers are kept.

module pattern_occurrence_distance_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	pod_byte_if.sink                             bytes,
	pod_result_if.source                         results,
	input  logic                                 cfg_we,
	input  logic [pod_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [pod_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	localparam int PB = pod_pkg::POSITION_BITS;

	// Registers
	logic [pod_pkg::PAT_LEN_BITS-1:0] pat_len_q;
	logic [63:0]                      pat_lo_q;
	logic [63:0]                      pat_hi_q;
	logic                             report_q;

	// Input register
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;

	// Run state
	pod_pkg::pos_t seen_q;
	pod_pkg::pos_t prev_q;
	pod_pkg::pos_t count_q;
	logic          first_q;
	pod_pkg::pos_t sum_q;

	// Stage 2: match decided, gap still to form
	logic          v_s2;
	pod_pkg::pos_t start_s2;
	pod_pkg::pos_t prev_s2;
	pod_pkg::pos_t total_s2;
	pod_pkg::pos_t lastpos_s2;
	logic          gap_en_s2;
	logic          report_s2;
	logic          eos_s2;
	logic          found_s2;

	// Stage 3: gap known, sum still to accumulate
	logic          v_s3;
	pod_pkg::pos_t start_s3;
	pod_pkg::pos_t gap_s3;
	pod_pkg::pos_t total_s3;
	pod_pkg::pos_t lastpos_s3;
	logic          gap_en_s3;
	logic          report_s3;
	logic          eos_s3;
	logic          found_s3;

	logic [pod_pkg::PAT_IDX_BITS-1:0]  len_m1;
	pod_pkg::pos_t                     len_m1_ext;
	logic                              hit;
	logic                              hit_ok;
	logic                              fire_s1;
	logic                              room;
	logic [pod_pkg::FIFO_CNT_BITS:0]   reserve;
	logic [pod_pkg::FIFO_CNT_BITS-1:0] fill;
	pod_pkg::pos_t                     start;
	pod_pkg::pos_t                     sum_new;
	pod_pkg::result_t                  rep_res;
	pod_pkg::result_t                  sum_res;
	pod_pkg::result_t                  head;
	pod_pkg::push_t                    push;
	logic                              not_empty;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q <= pod_pkg::PAT_LEN_BITS'(1);
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			report_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (pod_pkg::cfg_idx_t'(cfg_index))
				pod_pkg::CFG_PATTERN_LENGTH: pat_len_q <= cfg_data[pod_pkg::PAT_LEN_BITS-1:0];
				pod_pkg::CFG_PATTERN_LOW:    pat_lo_q  <= cfg_data;
				pod_pkg::CFG_PATTERN_HIGH:   pat_hi_q  <= cfg_data;
				pod_pkg::CFG_REPORT_EACH:    report_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign len_m1     = pod_pkg::eff_len_m1(pat_len_q);
	assign len_m1_ext = PB'(len_m1);

	// Reserve two queue slots for every item in flight before taking another.
	assign reserve = (pod_pkg::FIFO_CNT_BITS+1)'(fill)
		+ (pod_pkg::FIFO_CNT_BITS+1)'({v_s2, 1'b0})
		+ (pod_pkg::FIFO_CNT_BITS+1)'({v_s3, 1'b0});
	assign room    = (reserve <= (pod_pkg::FIFO_CNT_BITS+1)'(pod_pkg::FIFO_DEPTH - 2));
	assign fire_s1 = v_s1 && room;
	assign bytes.ready = !v_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (bytes.ready) begin
			v_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.data_byte;
			eos_s1  <= bytes.end_of_stream;
		end
	end

	pod_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (fire_s1),
		.clear     (eos_s1),
		.data_byte (byte_s1),
		.len_m1    (len_m1),
		.pattern   ({pat_hi_q, pat_lo_q}),
		.hit       (hit)
	);

	// A hit counts only once the window holds a full pattern length.
	assign hit_ok = hit && (seen_q >= len_m1_ext);
	assign start  = seen_q - len_m1_ext;

	// Advance run state; drop it all after the last byte of a stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			prev_q  <= '0;
			count_q <= '0;
			first_q <= 1'b0;
		end else if (fire_s1) begin
			if (eos_s1) begin
				seen_q  <= '0;
				prev_q  <= '0;
				count_q <= '0;
				first_q <= 1'b0;
			end else begin
				seen_q <= seen_q + PB'(1);
				if (hit_ok) begin
					count_q <= count_q + PB'(1);
					first_q <= 1'b1;
					prev_q  <= start;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= fire_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			start_s2   <= start;
			prev_s2    <= prev_q;
			total_s2   <= hit_ok ? count_q + PB'(1) : count_q;
			lastpos_s2 <= hit_ok ? start : prev_q;
			gap_en_s2  <= hit_ok && first_q;
			report_s2  <= hit_ok && first_q && report_q;
			eos_s2     <= eos_s1;
			found_s2   <= hit_ok || first_q;
		end
		if (v_s2) begin
			start_s3   <= start_s2;
			gap_s3     <= start_s2 - prev_s2;
			total_s3   <= total_s2;
			lastpos_s3 <= lastpos_s2;
			gap_en_s3  <= gap_en_s2;
			report_s3  <= report_s2;
			eos_s3     <= eos_s2;
			found_s3   <= found_s2;
		end
	end

	// Accumulate the distance sum; hold it across items, clear at stream end.
	assign sum_new = gap_en_s3 ? sum_q + gap_s3 : sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (v_s3) begin
			sum_q <= eos_s3 ? '0 : sum_new;
		end
	end

	always_comb begin
		rep_res.kind           = pod_pkg::KIND_MATCH;
		rep_res.match_position = start_s3;
		rep_res.gap            = gap_s3;
		rep_res.match_total    = total_s3;
		rep_res.gap_sum        = sum_new;
		rep_res.found_any      = 1'b1;
		rep_res.run_end        = !eos_s3;

		sum_res.kind           = pod_pkg::KIND_SUMMARY;
		sum_res.match_position = lastpos_s3;
		sum_res.gap            = '0;
		sum_res.match_total    = total_s3;
		sum_res.gap_sum        = sum_new;
		sum_res.found_any      = found_s3;
		sum_res.run_end        = 1'b1;

		// Report goes ahead of the summary when both fall on the same byte.
		push.first  = report_s3 ? rep_res : sum_res;
		push.second = sum_res;
		if (!v_s3) begin
			push.count = 2'd0;
		end else begin
			push.count = 2'(report_s3) + 2'(eos_s3);
		end
	end

	pod_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (not_empty && results.ready),
		.not_empty (not_empty),
		.head      (head),
		.fill      (fill)
	);

	assign results.valid          = not_empty;
	assign results.kind           = head.kind;
	assign results.match_position = head.match_position;
	assign results.gap            = head.gap;
	assign results.match_total    = head.match_total;
	assign results.gap_sum        = head.gap_sum;
	assign results.found_any      = head.found_any;
	assign results.run_end        = head.run_end;

endmodule
